// ===== src/wrl_pkg.sv =====
// Package for the windowed RMS level meter: widths, status codes, queue entry type.
// Used by all modules of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package wrl_pkg;
	localparam int SAMPLE_BITS   = 16;
	localparam int POSITION_BITS = 20;
	localparam int CHANNEL_BITS  = 6;
	localparam int COUNT_BITS    = POSITION_BITS + 1;
	localparam int SUM_BITS      = 52;
	localparam int SQ_BITS       = 2 * SAMPLE_BITS;
	localparam int LOG_BITS      = 24;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
	localparam logic [17:0] DB_PER_OCTAVE_Q16 = 18'd197283;
	localparam logic signed [15:0] LEVEL_MIN = 16'sh8000;
	localparam logic signed [15:0] LEVEL_MAX = 16'sh7fff;

	localparam logic [1:0] CFG_WINDOW_START  = 2'd0;
	localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;
	localparam logic [1:0] CFG_REF_OFFSET    = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// One finished window handed from the accumulator to the log unit.
	typedef struct packed {
		logic [SUM_BITS-1:0]     square_sum;
		logic [COUNT_BITS-1:0]   summed_count;
		logic [CHANNEL_BITS-1:0] channel;
		status_t                 status;
	} window_t;

	typedef enum logic [1:0] {
		LG_IDLE = 2'd0,
		LG_SUM  = 2'd1,
		LG_CNT  = 2'd2,
		LG_OUT  = 2'd3
	} log_state_t;
endpackage
`default_nettype wire

// ===== src/wrl_front.sv =====
// Front part: accepts samples, squares and accumulates them per channel window.
// Depends on wrl_pkg; pushes one window_t per channel into the queue.
`timescale 1ns / 1ps
`default_nettype none
module wrl_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire signed [wrl_pkg::SAMPLE_BITS-1:0] sample,
	input  wire                              last_in_channel,
	input  wire [wrl_pkg::POSITION_BITS-1:0] window_start,
	input  wire [wrl_pkg::POSITION_BITS-1:0] window_length,
	output logic                             push,
	output wrl_pkg::window_t                 push_data,
	input  wire                              queue_full
);
	import wrl_pkg::*;

	logic [COUNT_BITS-1:0]   position_q;
	logic [SUM_BITS-1:0]     square_sum_q;
	logic [COUNT_BITS-1:0]   summed_count_q;
	logic                    emitted_q;
	logic [CHANNEL_BITS-1:0] channel_q;

	logic [SAMPLE_BITS-1:0] mag;
	logic [SQ_BITS-1:0]     sq;
	logic [SUM_BITS:0]      sum_wide;
	logic [SUM_BITS-1:0]    sum_new;
	logic [COUNT_BITS-1:0]  count_new;
	logic                   take, fill_hit, len_zero, accept;
	status_t                end_status;

	// A sample may end a window, so accept only when the queue has room.
	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign len_zero = (window_length == '0);

	always_comb begin
		mag = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
		sq  = SQ_BITS'(mag) * SQ_BITS'(mag);
		take = !emitted_q && (position_q >= COUNT_BITS'(window_start))
			&& (len_zero || summed_count_q < COUNT_BITS'(window_length))
			&& (summed_count_q != COUNT_MAX);
		sum_wide  = {1'b0, square_sum_q} + (SUM_BITS + 1)'(sq);
		sum_new   = square_sum_q;
		count_new = summed_count_q;
		if (take) begin
			sum_new   = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
			count_new = summed_count_q + 1'b1;
		end
		fill_hit = take && !len_zero && (count_new == COUNT_BITS'(window_length));
		if (count_new == '0) end_status = ST_EMPTY;
		else if (!len_zero) end_status = ST_SHORT;
		else end_status = ST_OK;

		push = accept && (fill_hit || (last_in_channel && !emitted_q));
		push_data.square_sum   = sum_new;
		push_data.summed_count = count_new;
		push_data.channel      = channel_q;
		push_data.status       = fill_hit ? ST_OK : end_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q     <= '0;
			square_sum_q   <= '0;
			summed_count_q <= '0;
			emitted_q      <= 1'b0;
			channel_q      <= '0;
		end else if (accept) begin
			if (last_in_channel) begin
				position_q     <= '0;
				square_sum_q   <= '0;
				summed_count_q <= '0;
				emitted_q      <= 1'b0;
				channel_q      <= channel_q + 1'b1;
			end else begin
				if (position_q != COUNT_MAX) position_q <= position_q + 1'b1;
				square_sum_q   <= sum_new;
				summed_count_q <= count_new;
				if (fill_hit) emitted_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/wrl_queue.sv =====
// Two-entry queue of finished windows between the accumulator and the log unit.
// Depends on wrl_pkg for window_t.
`timescale 1ns / 1ps
`default_nettype none
module wrl_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  wrl_pkg::window_t  push_data,
	output logic              full,
	input  wire               pop,
	output logic              not_empty,
	output wrl_pkg::window_t  head
);
	import wrl_pkg::*;

	window_t    entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/wrl_log.sv =====
// Back part: forms 10*log10(sum/count) + offset in Q8.8 with a bit-serial log2 unit.
// Depends on wrl_pkg; pops windows from the queue and holds one result register.
`timescale 1ns / 1ps
`default_nettype none
module wrl_log (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 not_empty,
	input  wrl_pkg::window_t                    head,
	output logic                                pop,
	input  wire signed [15:0]                   reference_offset_db,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [15:0]                  level_db,
	output logic [wrl_pkg::CHANNEL_BITS-1:0]    channel_number,
	output logic [1:0]                          status
);
	import wrl_pkg::*;

	log_state_t state_q, state_d;
	window_t    job_q;
	logic [31:0] m_q;          // Q30 mantissa being squared
	logic [4:0]  step_q;       // fraction bit in progress
	logic [LOG_BITS-1:0] r_q;  // log2 in Q16 being built
	logic [LOG_BITS-1:0] lsum_q;
	logic [5:0]  exp;
	logic [31:0] m_init;
	logic [63:0] m_sq;
	logic [33:0] m_next;
	logic        frac_bit;
	logic [SUM_BITS-1:0] src;
	logic signed [LOG_BITS:0]  d;
	logic signed [LOG_BITS+19:0] p;
	logic signed [LOG_BITS+19:0] q;
	logic signed [17:0] lv;
	logic        start, zero_case;

	// Leading-one search and normalization of the operand to a Q30 mantissa.
	always_comb begin
		src = (state_q == LG_CNT) ? SUM_BITS'(job_q.summed_count) : job_q.square_sum;
		exp = '0;
		for (int i = 0; i < SUM_BITS; i++) begin
			if (src[i]) exp = 6'(i);
		end
		if (exp <= 6'd30) m_init = 32'(src << (6'd30 - exp));
		else m_init = 32'(src >> (exp - 6'd30));
	end

	always_comb begin
		m_sq     = 64'(m_q) * 64'(m_q);
		m_next   = m_sq[63:30] >= 34'(32'h8000_0000) ? 34'(m_sq[63:31]) : m_sq[63:30];
		frac_bit = m_sq[61];
	end

	assign zero_case = (job_q.status == ST_EMPTY) || (job_q.square_sum == '0);
	assign start     = (state_q == LG_IDLE) && not_empty;
	assign pop       = start;

	always_comb begin
		state_d = state_q;
		case (state_q)
			LG_IDLE: if (not_empty) state_d = LG_SUM;
			LG_SUM:  if (step_q == 5'd16 || zero_case) state_d = zero_case ? LG_OUT : LG_CNT;
			LG_CNT:  if (step_q == 5'd16) state_d = LG_OUT;
			LG_OUT:  if (out_ready) state_d = LG_IDLE;
			default: state_d = LG_IDLE;
		endcase
	end

	always_comb begin
		d  = $signed({1'b0, lsum_q}) - $signed({1'b0, r_q});
		p  = d * $signed({1'b0, DB_PER_OCTAVE_Q16}) + (LOG_BITS + 20)'(25'sh80_0000);
		q  = p >>> 24;
		lv = 18'(q) + 18'(reference_offset_db);
	end

	always_ff @(posedge clk) begin
		if (start) job_q <= head;
		if (state_q == LG_SUM && state_d == LG_CNT) lsum_q <= r_q;
		if (state_q != LG_OUT && state_d == LG_OUT) begin
			if (zero_case) level_db <= LEVEL_MIN;
			else if (lv < 18'(LEVEL_MIN)) level_db <= LEVEL_MIN;
			else if (lv > 18'(LEVEL_MAX)) level_db <= LEVEL_MAX;
			else level_db <= lv[15:0];
			channel_number <= job_q.channel;
			status         <= job_q.status;
		end
	end

	// Log2 iterations: restart on each operand, one fraction bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			step_q  <= '0;
			m_q     <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == LG_IDLE && state_d == LG_SUM)
					|| (state_q == LG_SUM && state_d == LG_CNT)) begin
				step_q <= 5'd31;
			end else if (step_q == 5'd31) begin
				m_q    <= m_init;
				r_q    <= LOG_BITS'({exp, 16'b0});
				step_q <= 5'd0;
			end else if (step_q != 5'd16) begin
				m_q    <= 32'(m_next);
				if (frac_bit) r_q <= r_q | LOG_BITS'(24'h8000 >> step_q);
				step_q <= step_q + 1'b1;
			end
		end
	end

	assign out_valid = (state_q == LG_OUT);
endmodule
`default_nettype wire

// ===== src/windowed_rms_level_db_core.sv =====
// Top level of the windowed RMS level meter: config registers, front, queue, log unit.
// Depends on wrl_pkg, wrl_front, wrl_queue and wrl_log.
`timescale 1ns / 1ps
`default_nettype none
// Samples are taken one per cycle; the accumulator never waits on the log unit
// unless the two-entry window queue is full. The log unit pops a window only when
// idle; it then runs two log2 passes (each a load step, sixteen fraction bits and a
// hand-off step) and holds its output until out_ready. A window with zero energy or
// an empty window skips both passes. Channels shorter than the log unit's time per
// window will, in a long run, throttle input through the queue.
module windowed_rms_level_db_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire signed [15:0]  sample,
	input  wire                last_in_channel,
	output logic               out_valid,
	input  wire                out_ready,
	output logic signed [15:0] level_db,
	output logic [5:0]         channel_number,
	output logic [1:0]         status,
	input  wire                cfg_we,
	input  wire [1:0]          cfg_index,
	input  wire [19:0]         cfg_data
);
	import wrl_pkg::*;

	logic [POSITION_BITS-1:0] window_start_q, window_length_q;
	logic signed [15:0]       ref_offset_q;
	logic    push, full, pop, not_empty;
	window_t push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q  <= '0;
			window_length_q <= '0;
			ref_offset_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_START:  window_start_q  <= cfg_data;
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data;
				CFG_REF_OFFSET:    ref_offset_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	wrl_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .sample, .last_in_channel,
		.window_start(window_start_q), .window_length(window_length_q),
		.push, .push_data, .queue_full(full)
	);

	wrl_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full, .pop, .not_empty, .head
	);

	wrl_log u_log (
		.clk, .arst_n, .not_empty, .head, .pop,
		.reference_offset_db(ref_offset_q),
		.out_valid, .out_ready, .level_db, .channel_number, .status
	);
endmodule
`default_nettype wire
